// ===== sv/svpwm_pkg.sv =====
package svpwm_pkg;

   // Field widths
   localparam int Q_W      = 16;
   localparam int ANGLE_W  = 16;
   localparam int BUS_W    = 15;
   localparam int DUTY_W   = 12;
   localparam int SEC_W    = 3;
   localparam int MAG_W    = 16;

   // Fixed-point widths
   localparam int FRAC_W   = 17;   // 0..65536, fraction of one sector
   localparam int QV_W     = 31;   // Q30 values below two
   localparam int DVD_W    = 48;   // product of Q30 time and magnitude
   localparam int CLAMP_W  = 32;   // doubled duty clamped to 0..2^31
   localparam int SUM_W    = 50;   // signed duty sums

   localparam logic [BUS_W-1:0]  BUS_RESET = 15'd3072;
   localparam logic [DUTY_W-1:0] DUTY_MAX  = 12'd4095;

   localparam logic [QV_W-1:0] Q30_ONE   = 31'h4000_0000;
   localparam logic [QV_W-1:0] PI3_Q30   = 31'd1124419809;
   localparam logic [QV_W-1:0] SQRT3_Q30 = 31'd1859775393;

   // Reciprocals for exact truncating division of 31-bit values
   localparam logic [5:0]  SH72 = 6'd38;
   localparam logic [5:0]  SH42 = 6'd37;
   localparam logic [5:0]  SH20 = 6'd36;
   localparam logic [5:0]  SH6  = 6'd34;
   localparam logic [31:0] M72  = 32'(((64'd1 << 38) + 64'd71) / 64'd72);
   localparam logic [31:0] M42  = 32'(((64'd1 << 37) + 64'd41) / 64'd42);
   localparam logic [31:0] M20  = 32'(((64'd1 << 36) + 64'd19) / 64'd20);
   localparam logic [31:0] M6   = 32'(((64'd1 << 34) + 64'd5) / 64'd6);

   // Pipeline depths
   localparam int SIN_LAT  = 11;
   localparam int DIV_BPS  = 4;                  // quotient bits per stage
   localparam int DIV_STG  = DVD_W / DIV_BPS;
   localparam int PIPE_LEN = 1 + SIN_LAT + 1 + DIV_STG + 2;

   // Duty selection codes
   localparam logic [1:0] SEL_T0    = 2'd0;   // T0
   localparam logic [1:0] SEL_T1    = 2'd1;   // 2T1+T0
   localparam logic [1:0] SEL_T2    = 2'd2;   // 2T2+T0
   localparam logic [1:0] SEL_T1_T2 = 2'd3;   // 2T1+2T2+T0

   localparam logic [1:0] SEC_MAP [6][3] = '{
      '{SEL_T1_T2, SEL_T2,    SEL_T0},
      '{SEL_T1,    SEL_T1_T2, SEL_T0},
      '{SEL_T0,    SEL_T1_T2, SEL_T2},
      '{SEL_T0,    SEL_T1,    SEL_T1_T2},
      '{SEL_T2,    SEL_T0,    SEL_T1_T2},
      '{SEL_T1_T2, SEL_T0,    SEL_T1}
   };

   typedef logic [DUTY_W-1:0] duty_type;

   // Q30 product, truncated
   function automatic logic [QV_W-1:0] mul_q30(input logic [QV_W-1:0] a,
                                                input logic [QV_W-1:0] b);
      logic [2*QV_W-1:0] prod;
      prod = {{QV_W{1'b0}}, a} * {{QV_W{1'b0}}, b};
      return prod[QV_W+29:30];
   endfunction

   // Truncating division by a constant through its reciprocal
   function automatic logic [QV_W-1:0] div_const(input logic [QV_W-1:0] v,
                                                  input logic [31:0] m,
                                                  input logic [5:0] sh);
      logic [QV_W+31:0] prod;
      prod = {32'b0, v} * {{QV_W{1'b0}}, m};
      return QV_W'(prod >> sh);
   endfunction

endpackage

// ===== sv/svpwm_sin.sv =====
module svpwm_sin (
   input  logic                        clock,
   input  logic                        en,
   input  logic [svpwm_pkg::FRAC_W-1:0] frac,
   output logic [svpwm_pkg::QV_W-1:0]   sin_k
);
   import svpwm_pkg::*;

   logic [QV_W-1:0] x_ff [1:9];
   logic [QV_W-1:0] w_ff [2:7];
   logic [QV_W-1:0] t3_ff, p4_ff, t5_ff, p6_ff, t7_ff, p8_ff, t9_ff, s10_ff, k11_ff;
   logic [FRAC_W+QV_W-1:0] xprod;

   assign xprod = {{QV_W{1'b0}}, frac} * {{FRAC_W{1'b0}}, PI3_Q30};

   // Angle to radians, square, Horner steps of the series, then scale by sqrt(3)
   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[1] <= xprod[QV_W+15:16];
         for (int i = 2; i <= 9; i++) x_ff[i] <= x_ff[i-1];
         w_ff[2] <= mul_q30(x_ff[1], x_ff[1]);
         for (int i = 3; i <= 7; i++) w_ff[i] <= w_ff[i-1];
         t3_ff  <= Q30_ONE - div_const(w_ff[2], M72, SH72);
         p4_ff  <= mul_q30(w_ff[3], t3_ff);
         t5_ff  <= Q30_ONE - div_const(p4_ff, M42, SH42);
         p6_ff  <= mul_q30(w_ff[5], t5_ff);
         t7_ff  <= Q30_ONE - div_const(p6_ff, M20, SH20);
         p8_ff  <= mul_q30(w_ff[7], t7_ff);
         t9_ff  <= Q30_ONE - div_const(p8_ff, M6, SH6);
         s10_ff <= mul_q30(x_ff[9], t9_ff);
         k11_ff <= mul_q30(s10_ff, SQRT3_Q30);
      end
   end

   assign sin_k = k11_ff;

endmodule

// ===== sv/svpwm_div.sv =====
module svpwm_div (
   input  logic                        clock,
   input  logic                        en,
   input  logic [svpwm_pkg::DVD_W-1:0] dividend,
   input  logic [svpwm_pkg::BUS_W-1:0] divisor,
   output logic [svpwm_pkg::DVD_W-1:0] quotient
);
   import svpwm_pkg::*;

   logic [BUS_W-1:0] rem_ff [DIV_STG];
   logic [DVD_W-1:0] dvd_ff [DIV_STG];
   logic [BUS_W-1:0] rem_in [DIV_STG];
   logic [DVD_W-1:0] dvd_in [DIV_STG];

   // Restoring division, quotient bits shift in as dividend bits shift out
   always_comb begin
      logic [BUS_W:0]   r;
      logic [BUS_W-1:0] rem;
      logic [DVD_W-1:0] dvd;
      for (int s = 0; s < DIV_STG; s++) begin
         rem = (s == 0) ? '0 : rem_ff[(s == 0) ? 0 : s-1];
         dvd = (s == 0) ? dividend : dvd_ff[(s == 0) ? 0 : s-1];
         for (int b = 0; b < DIV_BPS; b++) begin
            r = {rem, dvd[DVD_W-1]};
            if (r >= {1'b0, divisor}) begin
               r   = r - {1'b0, divisor};
               dvd = {dvd[DVD_W-2:0], 1'b1};
            end else begin
               dvd = {dvd[DVD_W-2:0], 1'b0};
            end
            rem = r[BUS_W-1:0];
         end
         rem_in[s] = rem;
         dvd_in[s] = dvd;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s < DIV_STG; s++) begin
            rem_ff[s] <= rem_in[s];
            dvd_ff[s] <= dvd_in[s];
         end
      end
   end

   assign quotient = dvd_ff[DIV_STG-1];

endmodule

// ===== sv/space_vector_pwm_duty_unit.sv =====
// Space vector PWM duty unit. Each request beat carries a signed q-axis
// voltage and an electrical angle (65536 steps per turn); each response beat
// carries the three phase compare counts (0..4095) and the sector 1..6. The
// duty fractions are divided by the bus voltage held in the csr register
// (1/256 V units, 0 acts as 1), which may be written only while the unit is
// idle. The unit is a 27-stage pipeline: one beat is accepted every cycle while
// the skid entry of the output buffer is empty, the depth being set by the sine
// series multiplier chain and the 4-bit-per-stage bus voltage divider.
// A two-entry output buffer (output register and skid entry) parks one more beat
// while a response waits; the whole pipe stalls while the skid entry is full.
module space_vector_pwm_duty_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [14:0] csr_wr_data,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // q_voltage[15:0], elec_angle[31:16]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // duty_a, duty_b, duty_c, sector_num, zero pad
);
   import svpwm_pkg::*;

   localparam int SEC_LAST = 1 + SIN_LAT + 1 + DIV_STG;   // sector used at clamp
   localparam int OUT_W    = 3*DUTY_W + SEC_W;

   logic [BUS_W-1:0] bus_ff;
   logic [BUS_W-1:0] vbus;
   logic             en;
   logic             vld_ff [PIPE_LEN];
   logic [SEC_W-1:0] sec_ff [SEC_LAST];
   logic [MAG_W-1:0] mag_ff [1+SIN_LAT];
   logic [FRAC_W-1:0] f1_ff, f2_ff;
   logic [QV_W-1:0]  k1, k2;
   logic [DVD_W-1:0] d1_ff, d2_ff, t1, t2;
   logic [CLAMP_W-1:0] clamp_ff [3];
   logic [CLAMP_W-1:0] clamp_in [3];
   duty_type           cnt_ff [3];
   logic [SEC_W-1:0]   sec_cl_ff;
   logic [SEC_W-1:0]   sec_out_ff;

   logic [Q_W-1:0]     q_in;
   logic [ANGLE_W-1:0] ang_in, ang_adj;
   logic [ANGLE_W+2:0] ang6;
   logic               neg;

   logic [OUT_W-1:0] pipe_data, out_ff, skid_ff;
   logic             out_vld_ff, skid_vld_ff, push, pop;

   // Bus voltage register
   always_ff @(posedge clock) begin
      if (reset) begin
         bus_ff <= BUS_RESET;
      end else if (csr_wr_en) begin
         bus_ff <= csr_wr_data;
      end
   end
   assign vbus = (bus_ff == '0) ? BUS_W'(1) : bus_ff;

   // Advance the whole pipe while the output buffer has room
   assign en         = !skid_vld_ff;
   assign req_tready = en;

   // Fold sign into angle, add quarter turn, split into sector and offset
   assign q_in    = req_tdata[15:0];
   assign ang_in  = req_tdata[31:16];
   assign neg     = q_in[Q_W-1];
   assign ang_adj = ang_in + (neg ? 16'h8000 : 16'h0000) + 16'h4000;
   assign ang6    = {ang_adj, 2'b00} + {1'b0, ang_adj, 1'b0};

   always_ff @(posedge clock) begin
      if (en) begin
         mag_ff[0] <= neg ? (~q_in + 16'd1) : q_in;
         sec_ff[0] <= ang6[ANGLE_W+2:ANGLE_W];
         f1_ff     <= 17'h10000 - {1'b0, ang6[ANGLE_W-1:0]};
         f2_ff     <= {1'b0, ang6[ANGLE_W-1:0]};
         for (int i = 1; i < SEC_LAST; i++) sec_ff[i] <= sec_ff[i-1];
         for (int i = 1; i <= SIN_LAT; i++) mag_ff[i] <= mag_ff[i-1];
      end
   end

   // Valid bits ride along with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PIPE_LEN; i++) vld_ff[i] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= req_tvalid;
         for (int i = 1; i < PIPE_LEN; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   svpwm_sin u_sin1 (.clock(clock), .en(en), .frac(f1_ff), .sin_k(k1));
   svpwm_sin u_sin2 (.clock(clock), .en(en), .frac(f2_ff), .sin_k(k2));

   // Scale by magnitude
   always_ff @(posedge clock) begin
      if (en) begin
         d1_ff <= {{(MAG_W+1){1'b0}}, k1} * {{(DVD_W-MAG_W){1'b0}}, mag_ff[SIN_LAT]};
         d2_ff <= {{(MAG_W+1){1'b0}}, k2} * {{(DVD_W-MAG_W){1'b0}}, mag_ff[SIN_LAT]};
      end
   end

   svpwm_div u_div1 (.clock(clock), .en(en), .dividend(d1_ff), .divisor(vbus),
                     .quotient(t1));
   svpwm_div u_div2 (.clock(clock), .en(en), .dividend(d2_ff), .divisor(vbus),
                     .quotient(t2));

   // Form doubled duties per sector and clamp to 0..2^31
   always_comb begin
      logic signed [SUM_W-1:0] st1, st2, one, v [4];
      logic [1:0] sel;
      one  = SUM_W'(Q30_ONE);
      st1  = SUM_W'(t1);
      st2  = SUM_W'(t2);
      v[0] = one - st1 - st2;
      v[1] = one + st1 - st2;
      v[2] = one - st1 + st2;
      v[3] = one + st1 + st2;
      for (int p = 0; p < 3; p++) begin
         sel = SEC_MAP[(sec_ff[SEC_LAST-1] > 3'd5) ? 3'd5 : sec_ff[SEC_LAST-1]][p];
         if (v[sel] < 0) begin
            clamp_in[p] = '0;
         end else if (v[sel] > (SUM_W'(1) <<< 31)) begin
            clamp_in[p] = 32'h8000_0000;
         end else begin
            clamp_in[p] = v[sel][CLAMP_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int p = 0; p < 3; p++) clamp_ff[p] <= clamp_in[p];
         sec_cl_ff <= sec_ff[SEC_LAST-1] + 3'd1;
      end
   end

   // Scale to counts, carry the sector alongside
   always_ff @(posedge clock) begin
      logic [CLAMP_W+DUTY_W-1:0] prod;
      if (en) begin
         for (int p = 0; p < 3; p++) begin
            prod      = {{DUTY_W{1'b0}}, clamp_ff[p]} * {{CLAMP_W{1'b0}}, DUTY_MAX};
            cnt_ff[p] <= prod[DUTY_W+30:31];
         end
         sec_out_ff <= sec_cl_ff;
      end
   end

   assign pipe_data = {sec_out_ff, cnt_ff[2], cnt_ff[1], cnt_ff[0]};
   assign push      = vld_ff[PIPE_LEN-1] && en;
   assign pop       = out_vld_ff && rsp_tready;

   // Output register with skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         if (push) begin
            if (!out_vld_ff || pop) begin
               out_vld_ff <= 1'b1;
            end else begin
               skid_vld_ff <= 1'b1;
            end
         end else if (pop) begin
            if (skid_vld_ff) begin
               skid_vld_ff <= 1'b0;
            end else begin
               out_vld_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         if (!out_vld_ff || pop) begin
            out_ff <= pipe_data;
         end else begin
            skid_ff <= pipe_data;
         end
      end else if (pop && skid_vld_ff) begin
         out_ff <= skid_ff;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {1'b0, out_ff};

   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> out_vld_ff) else $error("skid entry held without output beat");

   a_sector_range: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff |-> (out_ff[OUT_W-1:OUT_W-SEC_W] != 3'd0 &&
                      out_ff[OUT_W-1:OUT_W-SEC_W] != 3'd7))
      else $error("sector out of range");

   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      (push && out_vld_ff && !rsp_tready) |=> skid_vld_ff)
      else $error("stalled beat not parked in skid");

   a_skid_drain: assert property (@(posedge clock) disable iff (reset)
      (skid_vld_ff && rsp_tready) |=> (!skid_vld_ff && out_vld_ff))
      else $error("skid entry not drained");

endmodule
